[sv/lss_pkg.sv]
// Shared types and constants of the lidar scan segmenter.
package lss_pkg;

  // Configuration port geometry: 64-bit data, registers at 8-byte spacing
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 5;

  // Register indexes
  localparam logic [1:0] REG_MAX_DIST = 2'd0;
  localparam logic [1:0] REG_MIN_GAP2 = 2'd1;
  localparam logic [1:0] REG_STEP_COS = 2'd2;

  // Register reset values
  localparam logic [15:0] MAX_DIST_RST = 16'd8000;
  localparam logic [32:0] MIN_GAP2_RST = 33'd10000;
  localparam logic [16:0] STEP_COS_RST = 17'd65535;

  // Cosine of one in unsigned Q1.16
  localparam logic [16:0] COS_ONE = 17'h10000;

  // Product of a cosine and a distance product is scaled back by this shift
  localparam int unsigned CROSS_SHIFT = 15;

  typedef struct packed {
    logic [15:0] max_distance;
    logic [32:0] min_gap_squared;
    logic [16:0] step_cosine;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming point
    logic mul;     // form squares and distance product
    logic sum;     // sum of squares, partial products with the cosine
    logic xterm;   // assemble the cross term
    logic commit;  // decide, update scan state, load result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit;    // current point closes an obstacle
  } status_t;

endpackage

[sv/lidar_scan_segmenter.sv]
// Top level of the lidar scan segmenter.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------------
//   in       | input     | in_valid_i / in_stall_o   | distance_i, angle_i, first_point_i
//   out      | output    | out_valid_o / out_stall_i | begin_angle_o, end_angle_o
//   config   | input     | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// A point steps through capture, multiply, sum/partial products, cross term,
// then the decision which can take the next point in the same cycle.
// The steps follow the chain of three registered arithmetic stages.
// A result beat appears the cycle after the decision.
// Reset clears the scan state to a previous point of distance zero, no obstacle open.
// A held output beat stalls the decision only if that point emits a beat.
module lidar_scan_segmenter #(
  parameter int unsigned DISTANCE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [DISTANCE_BITS-1:0]           distance_i,
  input  logic signed [15:0]                 angle_i,
  input  logic                               first_point_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [15:0]                 begin_angle_o,
  output logic signed [15:0]                 end_angle_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lss_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lss_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lss_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import lss_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t sts;

  lss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lss_dp #(
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .distance_i    (distance_i),
    .angle_i       (angle_i),
    .first_point_i (first_point_i),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .begin_angle_o (begin_angle_o),
    .end_angle_o   (end_angle_o)
  );

endmodule

[sv/lss_regs.sv]
// Configuration registers behind the APB-style port.
module lss_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lss_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lss_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lss_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output lss_pkg::cfg_t                      cfg_o
);
  import lss_pkg::*;

  logic [1:0]  reg_idx;
  logic        wr_en;
  logic [15:0] max_dist_q;
  logic [32:0] min_gap2_q;
  logic [16:0] step_cos_q;

  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MAX_DIST_RST;
      min_gap2_q <= MIN_GAP2_RST;
      step_cos_q <= STEP_COS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_DIST: max_dist_q <= pwdata[15:0];
        REG_MIN_GAP2: min_gap2_q <= pwdata[32:0];
        REG_STEP_COS: step_cos_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_MAX_DIST: prdata = {48'd0, max_dist_q};
      REG_MIN_GAP2: prdata = {31'd0, min_gap2_q};
      REG_STEP_COS: prdata = {47'd0, step_cos_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.max_distance    = max_dist_q;
  assign cfg_o.min_gap_squared = min_gap2_q;
  assign cfg_o.step_cosine     = step_cos_q;

endmodule

[sv/lss_ctrl.sv]
// Sequencer of the segmenter: steps one point through the datapath.
module lss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lss_pkg::cmd_t    cmd_o,
  input  lss_pkg::status_t sts_i
);
  import lss_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_CROSS = 3'd3;
  localparam logic [2:0] ST_DEC   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       blocked, commit, in_ready, in_acc;

  // Decision waits only if it produces a beat and the output register is held
  assign blocked  = sts_i.emit & out_valid_q & out_stall_i;
  assign commit   = (state_q == ST_DEC) & ~blocked;
  assign in_ready = (state_q == ST_IDLE) | commit;
  assign in_acc   = in_valid_i & in_ready;

  assign in_stall_o  = ~in_ready;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_CROSS;
      ST_CROSS: state_d = ST_DEC;
      ST_DEC: begin
        if (commit) state_d = in_acc ? ST_MUL : ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Output valid: set by an emitting decision, cleared when the beat is taken
  assign out_valid_d = (commit & sts_i.emit) | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Commands
  assign cmd_o.load   = in_acc;
  assign cmd_o.mul    = (state_q == ST_MUL);
  assign cmd_o.sum    = (state_q == ST_SUM);
  assign cmd_o.xterm  = (state_q == ST_CROSS);
  assign cmd_o.commit = commit;

endmodule

[sv/lss_dp.sv]
// Datapath: gap by the law of cosines, obstacle decision and scan state.
module lss_dp #(
  parameter int unsigned DISTANCE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [DISTANCE_BITS-1:0] distance_i,
  input  logic signed [15:0]       angle_i,
  input  logic                     first_point_i,
  input  lss_pkg::cfg_t            cfg_i,
  input  lss_pkg::cmd_t            cmd_i,
  output lss_pkg::status_t         sts_o,
  output logic signed [15:0]       begin_angle_o,
  output logic signed [15:0]       end_angle_o
);
  import lss_pkg::*;

  localparam int unsigned DB     = DISTANCE_BITS;
  localparam int unsigned PW     = 2 * DB;            // square / product width
  localparam int unsigned HW     = DB + 17;           // half product times cosine
  localparam int unsigned FW     = PW + 17;           // full product times cosine
  localparam int unsigned CW     = FW - CROSS_SHIFT;  // cross term width
  localparam int unsigned CMPW   = (PW + 3 > 34) ? PW + 3 : 34;
  localparam int unsigned DCW    = (DB > 16) ? DB : 16;

  // Current point
  logic [DB-1:0]      cur_d_q;
  logic [15:0]        cur_a_q;
  logic               cur_first_q;
  // Scan state
  logic [DB-1:0]      prev_d_q;
  logic [15:0]        prev_a_q;
  logic               inside_q;
  logic [15:0]        start_q;
  // Arithmetic stages
  logic [PW-1:0]      dd_q, pp_q, dp_q;
  logic [PW:0]        sum_q;
  logic [HW-1:0]      lo_q, hi_q;
  logic [CW-1:0]      cross_q;
  logic [FW-1:0]      cross_full;
  logic [16:0]        cos_sat;
  // Result register
  logic [15:0]        begin_q, end_q;
  // Decision
  logic               gap_ge, far, near, close_hit, inside_mid;
  logic               inside_d;
  logic [15:0]        start_d;
  logic [DCW-1:0]     d_ext, max_ext;

  assign cos_sat = (cfg_i.step_cosine > COS_ONE) ? COS_ONE : cfg_i.step_cosine;

  // Capture the accepted point
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_d_q     <= distance_i;
      cur_a_q     <= angle_i;
      cur_first_q <= first_point_i;
    end
  end

  // Squares and distance product
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      dd_q <= PW'(cur_d_q) * PW'(cur_d_q);
      pp_q <= PW'(prev_d_q) * PW'(prev_d_q);
      dp_q <= PW'(cur_d_q) * PW'(prev_d_q);
    end
  end

  // Sum of squares; distance product times cosine in two halves
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      sum_q <= (PW + 1)'(dd_q) + (PW + 1)'(pp_q);
      lo_q  <= HW'(dp_q[DB-1:0]) * HW'(cos_sat);
      hi_q  <= HW'(dp_q[PW-1:DB]) * HW'(cos_sat);
    end
  end

  // Cross term 2*d*p*cos, truncated
  assign cross_full = (FW'(hi_q) << DB) + FW'(lo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.xterm) begin
      cross_q <= cross_full[FW-1:CROSS_SHIFT];
    end
  end

  // Clamped gap >= minimum, without forming the clamped difference
  assign gap_ge = (cfg_i.min_gap_squared == 33'd0) |
                  (CMPW'(sum_q) >= (CMPW'(cross_q) + CMPW'(cfg_i.min_gap_squared)));

  assign d_ext   = DCW'(cur_d_q);
  assign max_ext = DCW'(cfg_i.max_distance);
  assign far     = d_ext > max_ext;
  assign near    = d_ext < max_ext;

  // Obstacle close / open decision
  always_comb begin
    close_hit  = 1'b0;
    inside_mid = 1'b0;
    inside_d   = inside_q;
    start_d    = start_q;
    if (cur_first_q) begin
      inside_d = near;
      if (near) start_d = cur_a_q;
    end else begin
      close_hit  = inside_q & (gap_ge | far);
      inside_mid = inside_q & ~close_hit;
      if (!inside_mid && near) begin
        inside_d = 1'b1;
        start_d  = cur_a_q;
      end else begin
        inside_d = inside_mid;
      end
    end
  end

  assign sts_o.emit = close_hit;

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_d_q <= '0;
      prev_a_q <= '0;
      inside_q <= 1'b0;
      start_q  <= '0;
    end else if (cmd_i.commit) begin
      prev_d_q <= cur_d_q;
      prev_a_q <= cur_a_q;
      inside_q <= inside_d;
      start_q  <= start_d;
    end
  end

  // Result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && close_hit) begin
      begin_q <= start_q;
      end_q   <= prev_a_q;
    end
  end

  assign begin_angle_o = begin_q;
  assign end_angle_o   = end_q;

endmodule

[sv/lss_checker.sv]
// Port-level checks of the segmenter and their binding to the top level.
module lss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] begin_angle_o,
  input logic [15:0] end_angle_o
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  // A held output beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A held output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(begin_angle_o) && $stable(end_angle_o))
    else $error("output payload changed while stalled");

  // A point occupies the datapath in the multiply, sum and cross-term states after it is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("point taken while datapath busy");

  // A fresh result beat comes from a point that went through the multiply, sum, cross-term and decision states
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 5))
    else $error("result beat without a matching point");

endmodule

bind lidar_scan_segmenter lss_checker u_lss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .begin_angle_o (begin_angle_o),
  .end_angle_o   (end_angle_o)
);
